// ----- hw/rtl/pen_stroke_byte_stream_parser_defines.svh -----
// ----------------------------------------------------------------------------
// Pen stroke parser assertion macros
// Shared helpers for the concurrent checks in the parser modules.
// ----------------------------------------------------------------------------
`ifndef PEN_STROKE_BYTE_STREAM_PARSER_DEFINES_SVH
`define PEN_STROKE_BYTE_STREAM_PARSER_DEFINES_SVH

// Check sampled on the rising clock edge, muted while reset is held.
`define PSBP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check sampled on every rising clock edge, reset included.
`define PSBP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/psbp_pkg.sv -----
// ----------------------------------------------------------------------------
// Pen stroke parser package
// Types, codes and constants shared by the parser front end, queue and
// output stage.
// ----------------------------------------------------------------------------
package psbp_pkg;

    localparam int MAGIC_LEN_DEF = 32;
    localparam int SIG_MAX       = 32;
    localparam int IDX_W         = 5;
    localparam int QUEUE_DEPTH   = 2;
    localparam int OUT_TDATA_W   = 48;

    localparam logic [7:0] TAG_SKIP_A   = 8'h90;
    localparam logic [7:0] TAG_SKIP_B   = 8'h88;
    localparam logic [7:0] TAG_COLOR_LO = 8'd128;
    localparam logic [7:0] TAG_COLOR_HI = 8'd135;
    localparam logic [7:0] VERSION_ONE  = 8'd1;
    localparam logic [7:0] PAGE_MAX     = 8'd9;
    localparam logic [3:0] PAGE_UNKNOWN = 4'd10;

    // File signature, first byte at index zero.
    localparam logic [7:0] SIG_TABLE [SIG_MAX] = '{
        8'h41, 8'h43, 8'h45, 8'h43, 8'h41, 8'h44, 8'h5F, 8'h44,
        8'h49, 8'h47, 8'h49, 8'h4D, 8'h45, 8'h4D, 8'h4F, 8'h5F,
        8'h48, 8'h41, 8'h4E, 8'h44, 8'h57, 8'h52, 8'h49, 8'h54,
        8'h49, 8'h4E, 8'h47, 8'h5F, 8'h5F, 8'h5F, 8'h5F, 8'h5F
    };

    typedef enum logic [3:0] {
        PH_MAGIC   = 4'd0,
        PH_VERSION = 4'd1,
        PH_W0      = 4'd2,
        PH_W1      = 4'd3,
        PH_H0      = 4'd4,
        PH_H1      = 4'd5,
        PH_PAGE    = 4'd6,
        PH_PAD0    = 4'd7,
        PH_PAD1    = 4'd8,
        PH_BODY    = 4'd9
    } phase_t;

    typedef enum logic [1:0] {
        KIND_SIZE  = 2'd0,
        KIND_PAGE  = 2'd1,
        KIND_POINT = 2'd2,
        KIND_ERROR = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ERR_MAGIC   = 2'd0,
        ERR_VERSION = 2'd1,
        ERR_PADDING = 2'd2
    } err_t;

    // One classified result on its way to the output stage. The output
    // stage forms coord_y as y_base - y_sub.
    typedef struct packed {
        kind_t       kind;
        logic [15:0] x;
        logic [15:0] y_base;
        logic [14:0] y_sub;
        logic [1:0]  colour;
        logic        stroke;
        logic [3:0]  page;
        err_t        err;
    } psbp_rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } psbp_qstat_t;

endpackage

// ----- hw/rtl/pen_stroke_byte_stream_parser.sv -----
// ----------------------------------------------------------------------------
// Pen stroke byte stream parser
// Parses a handwriting file one byte at a time and reports image size,
// page type, pen points and header errors.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload
// s_*      in   tdata: byte_in; tuser: file_start
// m_*      out  tdata: coord_x, coord_y, pen_colour, stroke_start, page_code,
//               error_code; tuser: kind
//
// One byte is accepted per cycle while s_tready is high; m_tvalid for its
// result rises once the record has passed the result queue and the output register.
// The rate is set by the front end's combinational header and tag decode.
// s_tready drops only while the two-entry result queue is full.
// Reset is asynchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module pen_stroke_byte_stream_parser #(
    parameter int MAGIC_LEN = psbp_pkg::MAGIC_LEN_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,  // [7:0] byte_in
    input  logic                              s_tuser,  // [0] file_start
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [15:0] coord_x, [32:16] coord_y, [34:33] pen_colour, [35] stroke_start,
    // [39:36] page_code, [41:40] error_code, [47:42] zero
    output logic [psbp_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic [1:0]                        m_tuser   // [1:0] kind
);
    import psbp_pkg::*;

    logic        fire;
    logic        push;
    logic        pop;
    psbp_rec_t   rec;
    psbp_rec_t   head;
    psbp_qstat_t stat;

    assign s_tready = !stat.full;
    assign fire     = s_tvalid && s_tready;

    psbp_front #(
        .MAGIC_LEN (MAGIC_LEN)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .byte_in    (s_tdata),
        .file_start (s_tuser),
        .push       (push),
        .rec        (rec)
    );

    psbp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (rec),
        .pop      (pop),
        .head     (head),
        .stat     (stat)
    );

    psbp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .stat     (stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ----- hw/rtl/psbp_front.sv -----
// ----------------------------------------------------------------------------
// Pen stroke parser front end
// Walks the file header and the tag body one byte per transaction and
// pushes one result record for every byte that produces a result.
// ----------------------------------------------------------------------------
`include "pen_stroke_byte_stream_parser_defines.svh"

module psbp_front #(
    parameter int MAGIC_LEN = psbp_pkg::MAGIC_LEN_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic [7:0]          byte_in,
    input  logic                file_start,
    output logic                push,
    output psbp_pkg::psbp_rec_t rec
);
    import psbp_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAGIC_LEN - 1);

    phase_t           phase_reg, phase_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [15:0]      width_reg, width_next;
    logic [15:0]      height_reg, height_next;
    logic [7:0]       pb0_reg, pb0_next;
    logic [7:0]       pb1_reg, pb1_next;
    logic [7:0]       pb2_reg, pb2_next;
    logic [1:0]       pcnt_reg, pcnt_next;
    logic             skip_reg, skip_next;
    logic [1:0]       colour_reg, colour_next;
    logic             pend_reg, pend_next;
    logic             err_reg, err_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_MAGIC;
            idx_reg    <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            pb0_reg    <= '0;
            pb1_reg    <= '0;
            pb2_reg    <= '0;
            pcnt_reg   <= '0;
            skip_reg   <= 1'b0;
            colour_reg <= '0;
            pend_reg   <= 1'b1;
            err_reg    <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            idx_reg    <= idx_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            pb0_reg    <= pb0_next;
            pb1_reg    <= pb1_next;
            pb2_reg    <= pb2_next;
            pcnt_reg   <= pcnt_next;
            skip_reg   <= skip_next;
            colour_reg <= colour_next;
            pend_reg   <= pend_next;
            err_reg    <= err_next;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        width_next  = width_reg;
        height_next = height_reg;
        pb0_next    = pb0_reg;
        pb1_next    = pb1_reg;
        pb2_next    = pb2_reg;
        pcnt_next   = pcnt_reg;
        skip_next   = skip_reg;
        colour_next = colour_reg;
        pend_next   = pend_reg;
        err_next    = err_reg;
        push        = 1'b0;
        rec         = '0;

        if (fire)
        begin
            // A file start byte is parsed from the reset state.
            if (file_start)
            begin
                phase_next  = PH_MAGIC;
                idx_next    = '0;
                width_next  = '0;
                height_next = '0;
                pb0_next    = '0;
                pb1_next    = '0;
                pb2_next    = '0;
                pcnt_next   = '0;
                skip_next   = 1'b0;
                colour_next = '0;
                pend_next   = 1'b1;
                err_next    = 1'b0;
            end

            if (!err_next)
            begin
                unique case (phase_next)
                    PH_MAGIC:
                    begin
                        if (byte_in != SIG_TABLE[idx_next])
                        begin
                            err_next = 1'b1;
                            push     = 1'b1;
                            rec.kind = KIND_ERROR;
                            rec.err  = ERR_MAGIC;
                        end
                        else if (idx_next == LAST_IDX)
                        begin
                            idx_next   = '0;
                            phase_next = PH_VERSION;
                        end
                        else
                        begin
                            idx_next = idx_next + 1'b1;
                        end
                    end
                    PH_VERSION:
                    begin
                        if (byte_in != VERSION_ONE)
                        begin
                            err_next = 1'b1;
                            push     = 1'b1;
                            rec.kind = KIND_ERROR;
                            rec.err  = ERR_VERSION;
                        end
                        else
                        begin
                            phase_next = PH_W0;
                        end
                    end
                    PH_W0:
                    begin
                        width_next[7:0] = byte_in;
                        phase_next      = PH_W1;
                    end
                    PH_W1:
                    begin
                        width_next[15:8] = byte_in;
                        phase_next       = PH_H0;
                    end
                    PH_H0:
                    begin
                        height_next[7:0] = byte_in;
                        phase_next       = PH_H1;
                    end
                    PH_H1:
                    begin
                        height_next[15:8] = byte_in;
                        phase_next        = PH_PAGE;
                        push              = 1'b1;
                        rec.kind          = KIND_SIZE;
                        rec.x             = width_next;
                        rec.y_base        = height_next;
                    end
                    PH_PAGE:
                    begin
                        phase_next = PH_PAD0;
                        push       = 1'b1;
                        rec.kind   = KIND_PAGE;
                        rec.page   = (byte_in <= PAGE_MAX) ? byte_in[3:0] : PAGE_UNKNOWN;
                    end
                    PH_PAD0:
                    begin
                        pb0_next   = byte_in;
                        phase_next = PH_PAD1;
                    end
                    PH_PAD1:
                    begin
                        if (byte_in != 8'd0 || pb0_next != 8'd0)
                        begin
                            err_next = 1'b1;
                            push     = 1'b1;
                            rec.kind = KIND_ERROR;
                            rec.err  = ERR_PADDING;
                        end
                        else
                        begin
                            pb0_next   = '0;
                            phase_next = PH_BODY;
                        end
                    end
                    PH_BODY:
                    begin
                        if (skip_next)
                        begin
                            skip_next = 1'b0;
                        end
                        else if (pcnt_next == 2'd1)
                        begin
                            pb1_next  = byte_in;
                            pcnt_next = 2'd2;
                        end
                        else if (pcnt_next == 2'd2)
                        begin
                            pb2_next  = byte_in;
                            pcnt_next = 2'd3;
                        end
                        else if (pcnt_next == 2'd3)
                        begin
                            pcnt_next  = '0;
                            push       = 1'b1;
                            rec.kind   = KIND_POINT;
                            rec.x      = {1'b0, pb1_next, 7'b0} | {8'b0, pb0_next};
                            rec.y_base = height_next;
                            rec.y_sub  = {byte_in, 7'b0} | {7'b0, pb2_next};
                            rec.colour = colour_next;
                            rec.stroke = pend_next;
                            pend_next  = 1'b0;
                        end
                        else if (byte_in == TAG_SKIP_A || byte_in == TAG_SKIP_B)
                        begin
                            skip_next = 1'b1;
                        end
                        else if (byte_in >= TAG_COLOR_LO && byte_in <= TAG_COLOR_HI)
                        begin
                            colour_next = byte_in[2:1];
                            if (byte_in[0])
                            begin
                                pend_next = 1'b1;
                            end
                        end
                        else if (!byte_in[7])
                        begin
                            pb0_next  = byte_in;
                            pcnt_next = 2'd1;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    `PSBP_ASSERT(a_sticky_error, (fire && err_reg && !file_start) |-> !push, "result after a latched error")
    `PSBP_ASSERT(a_point_in_body, (pcnt_reg != 2'd0) |-> (phase_reg == PH_BODY), "point bytes outside the body")
    `PSBP_ASSERT(a_idx_bound, (idx_reg <= LAST_IDX), "signature index past the signature length")

endmodule

// ----- hw/rtl/psbp_queue.sv -----
// ----------------------------------------------------------------------------
// Pen stroke parser result queue
// Two-entry queue of result records between the front end and the output
// stage, so that either side can stall on its own.
// ----------------------------------------------------------------------------
`include "pen_stroke_byte_stream_parser_defines.svh"

module psbp_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  psbp_pkg::psbp_rec_t   push_rec,
    input  logic                  pop,
    output psbp_pkg::psbp_rec_t   head,
    output psbp_pkg::psbp_qstat_t stat
);
    import psbp_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    psbp_rec_t        mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign do_push = push && !stat.full;
    assign do_pop  = pop && !stat.empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_rec;
        end
    end

    assign head = mem[rd_ptr_reg];
    assign stat = '{full: (count_reg == CNT_W'(QUEUE_DEPTH)), empty: (count_reg == '0)};

    `PSBP_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(QUEUE_DEPTH), "queue count past depth")

endmodule

// ----- hw/rtl/psbp_back.sv -----
// ----------------------------------------------------------------------------
// Pen stroke parser output stage
// Takes records from the queue, forms the flipped y coordinate and holds
// the result in the output register until it is taken.
// ----------------------------------------------------------------------------
module psbp_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  psbp_pkg::psbp_rec_t   head,
    input  psbp_pkg::psbp_qstat_t stat,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [psbp_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic [1:0]            m_tuser
);
    import psbp_pkg::*;

    localparam int PAD_W = OUT_TDATA_W - 42;

    logic                   valid_reg, valid_next;
    logic [OUT_TDATA_W-1:0] data_reg;
    logic [1:0]             user_reg;
    logic [16:0]            coord_y;

    assign pop     = !stat.empty && (!valid_reg || m_tready);
    assign coord_y = {1'b0, head.y_base} - {2'b0, head.y_sub};

    always_comb
    begin
        valid_next = valid_reg;
        if (pop)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg <= {{PAD_W{1'b0}}, head.err, head.page, head.stroke, head.colour,
                         coord_y, head.x};
            user_reg <= head.kind;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;

endmodule
